[rtl/core/gbfs_pkg.sv]
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid BFS distance block
// Cell word layout, item kind codes, register indexes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbfs_pkg;

  localparam int DIST_W    = 12;
  localparam int SUM_W     = 24;
  localparam int UNR_W     = 13;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int KIND_W    = 2;
  localparam int COORD_W   = 6;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [CFG_W-1:0]  ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0]  COLS_RST = 7'd64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SRC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // neighbor directions, visited in this order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic              wall;
    logic              visited;
    logic [DIST_W-1:0] distance;
  } cell_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SRC  = 13'b0000000000010,
    S_LDW  = 13'b0000000000100,
    S_POP  = 13'b0000000001000,
    S_HEAD = 13'b0000000010000,
    S_CTR  = 13'b0000000100000,
    S_NB   = 13'b0000001000000,
    S_NCHK = 13'b0000010000000,
    S_SCAN = 13'b0000100000000,
    S_EMIT = 13'b0001000000000,
    S_CLRQ = 13'b0010000000000,
    S_CLRC = 13'b0100000000000,
    S_CLRW = 13'b1000000000000
  } state_t;

endpackage

[rtl/core/grid_multi_source_bfs_distance_sum.sv]
// ----------------------------------------------------------------------------
// grid_multi_source_bfs_distance_sum: multi-source grid BFS with distance sum
// Items: load a cell, mark a source, or run; a run walks the queue, scans
//   the grid, emits the result and clears the visited marks.
// One item at a time; the cell memory takes one read per cycle.
// Sync active-low reset clears control; rows/cols go to 64; memories unreset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_multi_source_bfs_distance_sum
  import gbfs_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic                 in_is_wall,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [COORD_W-1:0]   in_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     out_distance_sum,
  output logic [UNR_W-1:0]     out_unreached_count
);

  // Sizes follow from the grid bounds. Coordinates are kept as row and
  // column; the flat cell address is row * MAX_COLS + col.
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int QPW   = $clog2(CELLS + 1);
  localparam int CRW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW    = CRW + CCW;
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int EMAX  = (ERW > ECW) ? ERW : ECW;
  localparam int CMP_W = ((EMAX > CFG_W) ? EMAX : CFG_W) + 1;

  function automatic logic [IDX_W-1:0] cell_addr(input logic [CRW-1:0] r,
                                                 input logic [CCW-1:0] c);
    return IDX_W'(r) * IDX_W'(MAX_COLS) + IDX_W'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state_r,   state_nxt;
  logic [QPW-1:0]    head_r,    head_nxt;
  logic [QPW-1:0]    tail_r,    tail_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]  rows_r,    rows_nxt;
  logic [CFG_W-1:0]  cols_r,    cols_nxt;
  logic              scan_iss_r, scan_iss_nxt;
  logic              scan_vld_r, scan_vld_nxt;

  logic [KIND_W-1:0] it_kind_r, it_kind_nxt;
  logic              it_wall_r, it_wall_nxt;
  logic              it_in_r,   it_in_nxt;
  logic [CRW-1:0]    it_row_r,  it_row_nxt;
  logic [CCW-1:0]    it_col_r,  it_col_nxt;
  logic [CRW-1:0]    cur_row_r, cur_row_nxt;
  logic [CCW-1:0]    cur_col_r, cur_col_nxt;
  logic [DIST_W-1:0] cur_dist_r, cur_dist_nxt;
  logic [1:0]        dir_r,     dir_nxt;
  logic [CRW-1:0]    nb_row_r,  nb_row_nxt;
  logic [CCW-1:0]    nb_col_r,  nb_col_nxt;
  logic [IDX_W-1:0]  nb_addr_r, nb_addr_nxt;
  logic [CRW-1:0]    scan_row_r, scan_row_nxt;
  logic [CCW-1:0]    scan_col_r, scan_col_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  logic [UNR_W-1:0]  unr_r,     unr_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;
  logic [UNR_W-1:0]  out_unr_r, out_unr_nxt;

  // --------------------------------------------------------------------------
  // Memories: one cell word per grid cell (wall, visited, distance) and the
  // walk queue of coordinates. Both read every cycle with registered data.
  // The visited bit of a cell is written by the load of that cell, so the
  // cell memory needs no clearing pass after reset.
  // --------------------------------------------------------------------------
  cell_t            cell_mem [CELLS];
  cell_t            cell_q_r;
  logic             cell_we;
  logic [IDX_W-1:0] cell_wa;
  logic [IDX_W-1:0] cell_ra;
  cell_t            cell_wd;

  logic [QW-1:0]    queue_mem [CELLS];
  logic [QW-1:0]    queue_q_r;
  logic             q_we;
  logic [QW-1:0]    q_wd;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    cell_q_r <= cell_mem[cell_ra];
  end

  // The queue is read at the head and written at the tail.
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail_r[IDX_W-1:0]] <= q_wd;
    end
    queue_q_r <= queue_mem[head_r[IDX_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Effective grid size: zero acts as one, above the bound acts as the bound.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] nr_c;
  logic [CMP_W-1:0] nc_c;

  always_comb begin
    if (rows_r == '0) begin
      nr_c = CMP_W'(1);
    end else if (CMP_W'(rows_r) > CMP_W'(MAX_ROWS)) begin
      nr_c = CMP_W'(MAX_ROWS);
    end else begin
      nr_c = CMP_W'(rows_r);
    end
    if (cols_r == '0) begin
      nc_c = CMP_W'(1);
    end else if (CMP_W'(cols_r) > CMP_W'(MAX_COLS)) begin
      nc_c = CMP_W'(MAX_COLS);
    end else begin
      nc_c = CMP_W'(cols_r);
    end
  end

  logic           in_grid;
  logic [CRW-1:0] in_r_c;
  logic [CCW-1:0] in_c_c;
  logic [CRW-1:0] q_row;
  logic [CCW-1:0] q_col;
  logic           q_in_grid;

  assign in_grid   = (CMP_W'(in_row) < nr_c) && (CMP_W'(in_col) < nc_c);
  assign in_r_c    = CRW'(in_row);
  assign in_c_c    = CCW'(in_col);
  assign q_row     = queue_q_r[QW-1:CCW];
  assign q_col     = queue_q_r[CCW-1:0];
  assign q_in_grid = (CMP_W'(q_row) < nr_c) && (CMP_W'(q_col) < nc_c);

  // Neighbor of the current cell in direction dir_r, and whether it lies in
  // the grid.
  logic           nb_ok;
  logic [CRW-1:0] nb_row_c;
  logic [CCW-1:0] nb_col_c;

  always_comb begin
    nb_row_c = cur_row_r;
    nb_col_c = cur_col_r;
    nb_ok    = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nb_ok    = (cur_row_r != '0);
        nb_row_c = cur_row_r - CRW'(1);
      end
      DIR_LEFT: begin
        nb_ok    = (cur_col_r != '0);
        nb_col_c = cur_col_r - CCW'(1);
      end
      DIR_DOWN: begin
        nb_ok    = (CMP_W'(cur_row_r) + CMP_W'(1) < nr_c);
        nb_row_c = cur_row_r + CRW'(1);
      end
      DIR_RIGHT: begin
        nb_ok    = (CMP_W'(cur_col_r) + CMP_W'(1) < nc_c);
        nb_col_c = cur_col_r + CCW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Scan accumulation with saturation of the sum.
  logic [SUM_W:0] sum_add;
  logic           scan_last_col;
  logic           scan_last_row;

  assign sum_add       = {1'b0, sum_r} + (SUM_W + 1)'(cell_q_r.distance);
  assign scan_last_col = (CMP_W'(scan_col_r) + CMP_W'(1) == nc_c);
  assign scan_last_row = (CMP_W'(scan_row_r) + CMP_W'(1) == nr_c);

  logic queue_room;
  assign queue_room = (tail_r < QPW'(CELLS));

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    scan_iss_nxt  = scan_iss_r;
    scan_vld_nxt  = scan_vld_r;
    it_kind_nxt   = it_kind_r;
    it_wall_nxt   = it_wall_r;
    it_in_nxt     = it_in_r;
    it_row_nxt    = it_row_r;
    it_col_nxt    = it_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cur_dist_nxt  = cur_dist_r;
    dir_nxt       = dir_r;
    nb_row_nxt    = nb_row_r;
    nb_col_nxt    = nb_col_r;
    nb_addr_nxt   = nb_addr_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    sum_nxt       = sum_r;
    unr_nxt       = unr_r;
    out_sum_nxt   = out_sum_r;
    out_unr_nxt   = out_unr_r;

    cell_we = 1'b0;
    cell_wa = nb_addr_r;
    cell_ra = nb_addr_r;
    cell_wd = cell_q_r;
    q_we    = 1'b0;
    q_wd    = {nb_row_r, nb_col_r};

    in_ready = (state_r == S_IDLE);

    // Write configuration registers directly; the user must change them only while idle (not enforced here).
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_nxt = cfg_data;
        REG_COLS: cols_nxt = cfg_data;
        default:  ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // Capture the transaction and start the cell read a source needs.
        cell_ra = cell_addr(in_r_c, in_c_c);
        if (in_valid) begin
          it_kind_nxt = in_kind;
          it_wall_nxt = in_is_wall;
          it_in_nxt   = in_grid;
          it_row_nxt  = in_r_c;
          it_col_nxt  = in_c_c;
          nb_addr_nxt = cell_addr(in_r_c, in_c_c);
          case (in_kind)
            KIND_LOAD: begin
              // A load first drops every queued cell's visited mark.
              head_nxt  = '0;
              state_nxt = (tail_r != '0) ? S_CLRQ : S_LDW;
            end
            KIND_SRC: begin
              if (in_grid) begin
                state_nxt = S_SRC;
              end
            end
            KIND_RUN: begin
              state_nxt = S_POP;
            end
            default: ;
          endcase
        end
      end

      S_SRC: begin
        // Queue the source unless it is already marked; keep the wall bit.
        if (!cell_q_r.visited && queue_room) begin
          cell_we          = 1'b1;
          cell_wd.visited  = 1'b1;
          cell_wd.distance = '0;
          q_we             = 1'b1;
          q_wd             = {it_row_r, it_col_r};
          tail_nxt         = tail_r + QPW'(1);
        end
        state_nxt = S_IDLE;
      end

      S_LDW: begin
        // The clearing pass reuses nb_addr_r, so address the loaded cell here.
        cell_wa = cell_addr(it_row_r, it_col_r);
        if (it_in_r) begin
          cell_we          = 1'b1;
          cell_wd.wall     = it_wall_r;
          cell_wd.visited  = 1'b0;
          cell_wd.distance = '0;
        end
        state_nxt = S_IDLE;
      end

      S_POP: begin
        // Queue data for head_r is ready next cycle; an empty queue ends
        // the walk and starts the scan.
        if (head_r == tail_r) begin
          scan_row_nxt = '0;
          scan_col_nxt = '0;
          scan_iss_nxt = 1'b1;
          scan_vld_nxt = 1'b0;
          sum_nxt      = '0;
          unr_nxt      = '0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_HEAD;
        end
      end

      S_HEAD: begin
        // Pop; a cell left outside a shrunk grid does not spread.
        head_nxt = head_r + QPW'(1);
        cell_ra  = cell_addr(q_row, q_col);
        if (q_in_grid) begin
          cur_row_nxt = q_row;
          cur_col_nxt = q_col;
          state_nxt   = S_CTR;
        end else begin
          state_nxt = S_POP;
        end
      end

      S_CTR: begin
        cur_dist_nxt = (cell_q_r.distance == DIST_MAX) ? DIST_MAX
                                                       : cell_q_r.distance + DIST_W'(1);
        dir_nxt      = DIR_UP;
        state_nxt    = S_NB;
      end

      S_NB: begin
        cell_ra = cell_addr(nb_row_c, nb_col_c);
        if (nb_ok) begin
          nb_row_nxt  = nb_row_c;
          nb_col_nxt  = nb_col_c;
          nb_addr_nxt = cell_addr(nb_row_c, nb_col_c);
          state_nxt   = S_NCHK;
        end else if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end

      S_NCHK: begin
        // Reach an open, unmarked neighbor: mark, set distance, queue it.
        if (!cell_q_r.wall && !cell_q_r.visited && queue_room) begin
          cell_we          = 1'b1;
          cell_wd.visited  = 1'b1;
          cell_wd.distance = cur_dist_r;
          q_we             = 1'b1;
          tail_nxt         = tail_r + QPW'(1);
        end
        if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = S_NB;
        end
      end

      S_SCAN: begin
        // Issue one cell read a cycle in row order; each is summed in the cycle after.
        cell_ra      = cell_addr(scan_row_r, scan_col_r);
        scan_vld_nxt = scan_iss_r;
        if (scan_iss_r) begin
          if (scan_last_col) begin
            scan_col_nxt = '0;
            if (scan_last_row) begin
              scan_iss_nxt = 1'b0;
            end else begin
              scan_row_nxt = scan_row_r + CRW'(1);
            end
          end else begin
            scan_col_nxt = scan_col_r + CCW'(1);
          end
        end
        if (scan_vld_r && !cell_q_r.wall) begin
          if (cell_q_r.visited) begin
            sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          end else begin
            unr_nxt = unr_r + UNR_W'(1);
          end
        end
        if (!scan_iss_r && !scan_vld_r) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        // Hold until the output register is free, then drop the sources.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_unr_nxt   = unr_r;
          head_nxt      = '0;
          state_nxt     = (tail_r != '0) ? S_CLRQ : S_IDLE;
        end
      end

      S_CLRQ: begin
        state_nxt = S_CLRC;
      end

      S_CLRC: begin
        cell_ra     = cell_addr(q_row, q_col);
        nb_addr_nxt = cell_addr(q_row, q_col);
        state_nxt   = S_CLRW;
      end

      S_CLRW: begin
        // Queue entries are distinct cells, so one pass clears every mark.
        cell_we         = 1'b1;
        cell_wd.visited = 1'b0;
        if (head_r + QPW'(1) == tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = (it_kind_r == KIND_LOAD) ? S_LDW : S_IDLE;
        end else begin
          head_nxt  = head_r + QPW'(1);
          state_nxt = S_CLRQ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      scan_iss_r  <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      scan_iss_r  <= scan_iss_nxt;
      scan_vld_r  <= scan_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_kind_r  <= it_kind_nxt;
    it_wall_r  <= it_wall_nxt;
    it_in_r    <= it_in_nxt;
    it_row_r   <= it_row_nxt;
    it_col_r   <= it_col_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    cur_dist_r <= cur_dist_nxt;
    dir_r      <= dir_nxt;
    nb_row_r   <= nb_row_nxt;
    nb_col_r   <= nb_col_nxt;
    nb_addr_r  <= nb_addr_nxt;
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    sum_r      <= sum_nxt;
    unr_r      <= unr_nxt;
    out_sum_r  <= out_sum_nxt;
    out_unr_r  <= out_unr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_distance_sum    = out_sum_r;
  assign out_unreached_count = out_unr_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (tail_r <= QPW'(CELLS)))
    else $error("walk queue pointers out of order");

  a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> (cell_we && cell_wd.visited))
    else $error("queue push without marking the cell");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule
